// ----- rtl/core/e2q_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the Euler to quaternion block.
package e2q_pkg;

  localparam int unsigned ANGLE_BITS = 32;
  localparam int unsigned QUAT_BITS  = 32;
  localparam int unsigned FRAC       = 62;

  localparam logic [63:0] PI_Q62         = 64'hC90FDAA22168C235;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] KGAIN_Q62      = 64'h26DD3B6A10D7969A;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_scalar;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } e2q_out_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    udiv64 = q;
  endfunction

  function automatic logic [63:0] atan_q62(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned e;
    sum = '0;
    if (i == 0) begin
      sum = QUARTER_PI_Q62;
    end else begin
      for (int unsigned k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= FRAC) begin
          term = udiv64(64'd1 << (FRAC - e), 64'(2 * k + 1));
          if (k[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
    end
    atan_q62 = sum;
  endfunction

endpackage

// ----- rtl/core/e2q_rmul.sv -----
// Three-stage unsigned 64x64 multiplier with round-half-up shift and sign restore.
module e2q_rmul #(
  parameter int unsigned SHIFT = 62
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] mag_a,
  input  logic [63:0] mag_b,
  input  logic        neg,
  output logic [63:0] prod
);

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic         neg1_r, neg2_r;
  logic [127:0] sum_r, sum_nxt;
  logic [127:0] rnd;
  logic [63:0]  prod_r, prod_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= 64'(mag_a[31:0])  * 64'(mag_b[31:0]);
      lh_r   <= 64'(mag_a[31:0])  * 64'(mag_b[63:32]);
      hl_r   <= 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
      hh_r   <= 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
      neg1_r <= neg;
    end
  end

  assign sum_nxt = {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0}
                 + {hh_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      neg2_r <= neg1_r;
    end
  end

  assign rnd      = sum_r + (128'd1 << (SHIFT - 1));
  assign prod_nxt = neg2_r ? (64'd0 - rnd[SHIFT+63:SHIFT]) : rnd[SHIFT+63:SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ----- rtl/core/e2q_cordic_lane.sv -----
// One angle lane: binary angle to radians, then pipelined CORDIC for half-angle cos and sin.
module e2q_cordic_lane #(
  parameter int unsigned CORDIC_STAGES = 28
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [e2q_pkg::ANGLE_BITS-1:0]   angle,
  output logic [63:0]                      cos_out,
  output logic [63:0]                      sin_out
);

  localparam int unsigned AB = e2q_pkg::ANGLE_BITS;

  logic [63:0] ang_ext;
  logic [63:0] z0;
  logic signed [63:0] x_r [CORDIC_STAGES];
  logic signed [63:0] y_r [CORDIC_STAGES];
  logic signed [63:0] z_r [CORDIC_STAGES];

  assign ang_ext = {{(64-AB){angle[AB-1]}}, angle};

  e2q_rmul #(.SHIFT(AB)) u_rad (
    .clk   (clk),
    .en    (en),
    .mag_a (e2q_pkg::mag64(ang_ext)),
    .mag_b (e2q_pkg::PI_Q62),
    .neg   (angle[AB-1]),
    .prod  (z0)
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [63:0] ATAN = e2q_pkg::atan_q62(i);
    logic signed [63:0] xp, yp, zp;
    logic signed [63:0] x_nxt, y_nxt, z_nxt;
    if (i == 0) begin : g_first
      assign xp = e2q_pkg::KGAIN_Q62;
      assign yp = '0;
      assign zp = z0;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end
    assign x_nxt = zp[63] ? (xp + (yp >>> i)) : (xp - (yp >>> i));
    assign y_nxt = zp[63] ? (yp - (xp >>> i)) : (yp + (xp >>> i));
    assign z_nxt = zp[63] ? (zp + ATAN) : (zp - ATAN);
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign cos_out = x_r[CORDIC_STAGES-1];
  assign sin_out = y_r[CORDIC_STAGES-1];

endmodule

// ----- rtl/core/e2q_merge.sv -----
// Merge stage: pair products, triple products, sums and rounding to the output format.
module e2q_merge (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       cr,
  input  logic [63:0]       sr,
  input  logic [63:0]       cp,
  input  logic [63:0]       sp,
  input  logic [63:0]       cy,
  input  logic [63:0]       sy,
  output e2q_pkg::e2q_out_t quat
);

  localparam int unsigned QB = e2q_pkg::QUAT_BITS;

  function automatic logic [QB-1:0] to_q(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] lim;
    r   = (e2q_pkg::mag64(v) + (64'd1 << (64 - QB - 1))) >> (64 - QB);
    lim = 64'd1 << (QB - 1);
    if (v[63]) begin
      if (r > lim) begin
        r = lim;
      end
      r = 64'd0 - r;
    end else if (r > lim - 64'd1) begin
      r = lim - 64'd1;
    end
    to_q = r[QB-1:0];
  endfunction

  logic [63:0] crcp, srsp, srcp, crsp;
  logic [63:0] cy_r [3];
  logic [63:0] sy_r [3];
  logic [63:0] p_a [4];
  logic [63:0] p_b [4];
  logic [63:0] s_r [4];
  e2q_pkg::e2q_out_t quat_r, quat_nxt;

  e2q_rmul #(.SHIFT(e2q_pkg::FRAC)) u_crcp (.clk(clk), .en(en),
    .mag_a(e2q_pkg::mag64(cr)), .mag_b(e2q_pkg::mag64(cp)), .neg(cr[63] ^ cp[63]), .prod(crcp));
  e2q_rmul #(.SHIFT(e2q_pkg::FRAC)) u_srsp (.clk(clk), .en(en),
    .mag_a(e2q_pkg::mag64(sr)), .mag_b(e2q_pkg::mag64(sp)), .neg(sr[63] ^ sp[63]), .prod(srsp));
  e2q_rmul #(.SHIFT(e2q_pkg::FRAC)) u_srcp (.clk(clk), .en(en),
    .mag_a(e2q_pkg::mag64(sr)), .mag_b(e2q_pkg::mag64(cp)), .neg(sr[63] ^ cp[63]), .prod(srcp));
  e2q_rmul #(.SHIFT(e2q_pkg::FRAC)) u_crsp (.clk(clk), .en(en),
    .mag_a(e2q_pkg::mag64(cr)), .mag_b(e2q_pkg::mag64(sp)), .neg(cr[63] ^ sp[63]), .prod(crsp));

  always_ff @(posedge clk) begin
    if (en) begin
      cy_r[0] <= cy;
      sy_r[0] <= sy;
      cy_r[1] <= cy_r[0];
      sy_r[1] <= sy_r[0];
      cy_r[2] <= cy_r[1];
      sy_r[2] <= sy_r[1];
    end
  end

  logic [63:0] fa [4];
  logic [63:0] fb [4];
  logic [63:0] ga [4];
  logic [63:0] gb [4];

  assign fa[0] = crcp; assign fb[0] = cy_r[2]; assign ga[0] = srsp; assign gb[0] = sy_r[2];
  assign fa[1] = srcp; assign fb[1] = cy_r[2]; assign ga[1] = crsp; assign gb[1] = sy_r[2];
  assign fa[2] = crsp; assign fb[2] = cy_r[2]; assign ga[2] = srcp; assign gb[2] = sy_r[2];
  assign fa[3] = crcp; assign fb[3] = sy_r[2]; assign ga[3] = srsp; assign gb[3] = cy_r[2];

  for (genvar j = 0; j < 4; j++) begin : g_tri
    e2q_rmul #(.SHIFT(e2q_pkg::FRAC)) u_pa (.clk(clk), .en(en),
      .mag_a(e2q_pkg::mag64(fa[j])), .mag_b(e2q_pkg::mag64(fb[j])),
      .neg(fa[j][63] ^ fb[j][63]), .prod(p_a[j]));
    e2q_rmul #(.SHIFT(e2q_pkg::FRAC)) u_pb (.clk(clk), .en(en),
      .mag_a(e2q_pkg::mag64(ga[j])), .mag_b(e2q_pkg::mag64(gb[j])),
      .neg(ga[j][63] ^ gb[j][63]), .prod(p_b[j]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= p_a[0] + p_b[0];
      s_r[1] <= p_a[1] - p_b[1];
      s_r[2] <= p_a[2] + p_b[2];
      s_r[3] <= p_a[3] - p_b[3];
    end
  end

  always_comb begin
    quat_nxt.quat_scalar = to_q(s_r[0]);
    quat_nxt.quat_x      = to_q(s_r[1]);
    quat_nxt.quat_y      = to_q(s_r[2]);
    quat_nxt.quat_z      = to_q(s_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_r <= quat_nxt;
    end
  end

  assign quat = quat_r;

endmodule

// ----- rtl/core/euler_to_quaternion_top.sv -----
// Top level: three CORDIC lanes feeding the quaternion merge pipeline.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_data  (roll, pitch, yaw)
//   out     | output    | out_valid/out_ready | out_data (scalar, x, y, z)
//
// One request per cycle while no result waits; the pipeline runs through the radian
// multiply, the CORDIC stages, two product levels, a sum register and rounding.
// Reset clears only the valid pipeline; payload registers are not reset.
// A waiting result halts the whole pipeline, and in_ready falls with it.
module euler_to_quaternion_top #(
  parameter int unsigned CORDIC_STAGES = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  e2q_pkg::e2q_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output e2q_pkg::e2q_out_t out_data
);

  localparam int unsigned LAT = CORDIC_STAGES + 11;

  logic            en;
  logic [LAT-1:0]  vld_r, vld_nxt;
  logic [63:0]     cr, sr, cp, sp, cy, sy;

  assign en       = ~vld_r[LAT-1] | out_ready;
  assign in_ready = en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_data.roll_angle), .cos_out(cr), .sin_out(sr));
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_data.pitch_angle), .cos_out(cp), .sin_out(sp));
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_data.yaw_angle), .cos_out(cy), .sin_out(sy));

  e2q_merge u_merge (
    .clk(clk), .en(en), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .quat(out_data));

  assign out_valid = vld_r[LAT-1];

endmodule

// ----- rtl/core/e2q_checker.sv -----
// Port-level checker for the Euler to quaternion block, bound to the top level.
module e2q_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input e2q_pkg::e2q_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed while stalled");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("request taken during stall");

  a_free_flows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input blocked with empty output");

endmodule

bind euler_to_quaternion_top e2q_checker u_chk (.*);
